@@ design/bdq_pkg.sv @@
// Shared types and constants for the bounded deque with search.
package bdq_pkg;

    // Store geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Fixed field widths on the stream ports
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int DOUT_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // Operation codes; codes 6 and 7 are no-ops
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_SEARCH     = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What a cell loads at the next edge
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_LOAD,
        ACT_FROM_LEFT,
        ACT_FROM_RIGHT
    } cell_act_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic en;
        op_t  op;
        logic full;
        logic empty;
    } cell_ctrl_t;

endpackage

@@ design/bdq_cell.sv @@
// One storage cell of the deque chain: holds an entry, compares it, shifts with neighbors.
module bdq_cell (
    input  logic               aclk,
    input  bdq_pkg::cell_ctrl_t ctrl,
    input  bdq_pkg::data_t     key,
    input  bdq_pkg::data_t     left_data,
    input  bdq_pkg::data_t     right_data,
    input  logic               occupied,
    input  logic               at_tail,
    input  logic               hit_in,
    output bdq_pkg::data_t     data,
    output logic               match,
    output logic               hit_out
);

    bdq_pkg::data_t    data_reg;
    bdq_pkg::data_t    data_next;
    bdq_pkg::cell_act_t act;

    // Compare and priority chain: hit_out marks this cell or any cell ahead of it
    assign match   = occupied && (data_reg == key);
    assign hit_out = hit_in || match;
    assign data    = data_reg;

    // Per-cell action decode
    always_comb begin
        act = bdq_pkg::ACT_HOLD;
        if (ctrl.en) begin
            case (ctrl.op)
                bdq_pkg::OP_PUSH_FRONT: begin
                    if (!ctrl.full) act = bdq_pkg::ACT_FROM_LEFT;
                end
                bdq_pkg::OP_PUSH_BACK: begin
                    if (!ctrl.full && at_tail) act = bdq_pkg::ACT_LOAD;
                end
                bdq_pkg::OP_POP_FRONT: begin
                    if (!ctrl.empty) act = bdq_pkg::ACT_FROM_RIGHT;
                end
                bdq_pkg::OP_REMOVE: begin
                    // cells at and behind the first match close the gap
                    if (hit_out) act = bdq_pkg::ACT_FROM_RIGHT;
                end
                default: act = bdq_pkg::ACT_HOLD;
            endcase
        end
    end

    // Next entry select
    always_comb begin
        case (act)
            bdq_pkg::ACT_LOAD:       data_next = key;
            bdq_pkg::ACT_FROM_LEFT:  data_next = left_data;
            bdq_pkg::ACT_FROM_RIGHT: data_next = right_data;
            default:                 data_next = data_reg;
        endcase
    end

    // Entry register; payload only, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

@@ design/bounded_deque_with_search.sv @@
// Top level of the bounded deque with search: cell chain, count and result register.
//
//  Channel | Ports                         | Payload (low bit first)
//  --------+-------------------------------+-------------------------------------------
//  input   | s_tvalid s_tready s_tdata[40] | op[2:0] value[34:3] zero[39:35]
//  result  | m_tvalid m_tready m_tdata[40] | data_out[31:0] found[32] status[34:33]
//          |                               | occupancy[39:35]
//
//  One transfer per cycle while s_tready is high; its result is registered.
//  Each cycle is bounded by the cell compare and the first-match chain through all cells.
//  Reset clears the entry count and the output valid; entries need no clearing.
//  A stalled result holds m_tdata; s_tready stays high while the result register can drain.
module bounded_deque_with_search (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bdq_pkg::S_TDATA_W-1:0] s_tdata,  // op[2:0], value[34:3], zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bdq_pkg::M_TDATA_W-1:0] m_tdata   // data_out, found, status, occupancy
);

    localparam int D = bdq_pkg::DEPTH;

    logic                 s_xfer;
    bdq_pkg::op_t         op;
    logic [bdq_pkg::VALUE_W-1:0] value;
    bdq_pkg::data_t       key;
    bdq_pkg::cell_ctrl_t  ctrl;

    bdq_pkg::cnt_t        count_reg;
    bdq_pkg::cnt_t        count_next;
    logic                 full;
    logic                 empty;

    bdq_pkg::data_t       cell_data [D];
    logic [D-1:0]         cell_match;
    logic [D:0]           hit_chain;
    logic [D-1:0]         occupied;
    logic [D-1:0]         at_tail;

    logic [bdq_pkg::IDX_W-1:0] back_idx;
    bdq_pkg::data_t       pop_data;
    logic [bdq_pkg::DOUT_W-1:0] data_out;
    logic                 found;
    bdq_pkg::status_t     status;

    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [bdq_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Handshake
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign op       = bdq_pkg::op_t'(s_tdata[bdq_pkg::OP_W-1:0]);
    assign value    = s_tdata[bdq_pkg::OP_W +: bdq_pkg::VALUE_W];
    assign key      = value[bdq_pkg::DATA_WIDTH-1:0];

    assign full  = (count_reg == bdq_pkg::CNT_W'(D));
    assign empty = (count_reg == '0);

    assign ctrl.en    = s_xfer;
    assign ctrl.op    = op;
    assign ctrl.full  = full;
    assign ctrl.empty = empty;

    assign hit_chain[0] = 1'b0;

    // Cell chain; cell 0 is the front, its left neighbor is the pushed value
    for (genvar i = 0; i < D; i++) begin : g_cell
        assign occupied[i] = (bdq_pkg::CNT_W'(i) < count_reg);
        assign at_tail[i]  = (bdq_pkg::CNT_W'(i) == count_reg);

        bdq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .key        (key),
            .left_data  ((i == 0) ? key : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data ((i == D - 1) ? '0 : cell_data[(i == D - 1) ? i : i + 1]),
            .occupied   (occupied[i]),
            .at_tail    (at_tail[i]),
            .hit_in     (hit_chain[i]),
            .data       (cell_data[i]),
            .match      (cell_match[i]),
            .hit_out    (hit_chain[i+1])
        );
    end

    // Back entry select for pop back
    assign back_idx = bdq_pkg::IDX_W'(count_reg - 1'b1);

    // Result and next count
    always_comb begin
        count_next = count_reg;
        pop_data   = '0;
        found      = 1'b0;
        status     = bdq_pkg::ST_OK;
        case (op)
            bdq_pkg::OP_PUSH_FRONT,
            bdq_pkg::OP_PUSH_BACK: begin
                if (full) status = bdq_pkg::ST_FULL;
                else      count_next = count_reg + 1'b1;
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    pop_data   = cell_data[0];
                    count_next = count_reg - 1'b1;
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    pop_data   = cell_data[back_idx];
                    count_next = count_reg - 1'b1;
                end
            end
            bdq_pkg::OP_REMOVE: begin
                found = hit_chain[D];
                if (hit_chain[D]) count_next = count_reg - 1'b1;
            end
            bdq_pkg::OP_SEARCH: begin
                found = hit_chain[D];
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    assign data_out = bdq_pkg::DOUT_W'(pop_data);

    // Count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (s_xfer) begin
            count_reg <= count_next;
        end
    end

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_xfer)        m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_tdata_reg <= {bdq_pkg::OCC_W'(count_next), status, found, data_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bdq_pkg::CNT_W'(D))
        else $error("entry count above depth");

    a_occ_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (m_tdata[39:35] == bdq_pkg::OCC_W'(count_reg)))
        else $error("reported occupancy differs from entry count");

    a_full_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && full && (op == bdq_pkg::OP_PUSH_FRONT || op == bdq_pkg::OP_PUSH_BACK)
        |=> (count_reg == $past(count_reg)) && (m_tdata[34:33] == bdq_pkg::ST_FULL))
        else $error("push on full store changed the store");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !empty && (op == bdq_pkg::OP_POP_FRONT || op == bdq_pkg::OP_POP_BACK)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not drop one entry");

    a_hit_any: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_chain[D] == (|cell_match))
        else $error("first-match chain disagrees with cell compares");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the bounded deque with search: directed and random op streams.
module testbench;

    // Op codes the block treats as no-ops
    localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    // Input transfer layout, top field first
    typedef struct packed {
        logic [bdq_pkg::S_TDATA_W-bdq_pkg::OP_W-bdq_pkg::VALUE_W-1:0] pad;
        logic [bdq_pkg::VALUE_W-1:0]                                 value;
        logic [bdq_pkg::OP_W-1:0]                                    op;
    } deque_cmd_t;

    // Result transfer layout, top field first
    typedef struct packed {
        logic [bdq_pkg::OCC_W-1:0]  occupancy;
        bdq_pkg::status_t           status;
        logic                       found;
        logic [bdq_pkg::DOUT_W-1:0] data_out;
    } deque_result_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [bdq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [bdq_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the store, front at index 0
    bdq_pkg::data_t shadow_store[$];
    deque_result_t  pending_results[$];

    int error_count = 0;
    int burst_left  = 0;
    bit tx_gaps_on  = 1'b1;
    int rx_cycle    = 0;

    bounded_deque_with_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Apply one op to the shadow store and return the result it must produce
    function automatic deque_result_t apply_deque_op(logic [bdq_pkg::OP_W-1:0] op,
                                                     bdq_pkg::data_t value);
        deque_result_t res;
        int            hit;
        res = '0;
        res.status = bdq_pkg::ST_OK;
        hit = -1;
        case (op)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                if (shadow_store.size() >= bdq_pkg::DEPTH)
                    res.status = bdq_pkg::ST_FULL;
                else if (op == bdq_pkg::OP_PUSH_FRONT)
                    shadow_store.push_front(value);
                else
                    shadow_store.push_back(value);
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                if (shadow_store.size() == 0)
                    res.status = bdq_pkg::ST_EMPTY;
                else if (op == bdq_pkg::OP_POP_FRONT)
                    res.data_out = shadow_store.pop_front();
                else
                    res.data_out = shadow_store.pop_back();
            end
            bdq_pkg::OP_REMOVE, bdq_pkg::OP_SEARCH: begin
                for (int i = 0; i < shadow_store.size(); i++) begin
                    if (hit < 0 && shadow_store[i] == value)
                        hit = i;
                end
                if (hit >= 0) begin
                    res.found = 1'b1;
                    if (op == bdq_pkg::OP_REMOVE)
                        shadow_store.delete(hit);
                end
            end
            default: ;
        endcase
        res.occupancy = bdq_pkg::OCC_W'(shadow_store.size());
        return res;
    endfunction

    // Value for a random op: mostly stored or small values so finds hit and duplicates occur
    function automatic bdq_pkg::data_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && shadow_store.size() > 0)
            return shadow_store[$urandom_range(0, shadow_store.size() - 1)];
        else if (r < 7)
            return bdq_pkg::data_t'($urandom_range(0, 7));
        else if (r == 7)
            case ($urandom_range(0, 2))
                0: return '0;
                1: return '1;
                default: return bdq_pkg::data_t'(32'h8000_0000);
            endcase
        return bdq_pkg::data_t'($urandom);
    endfunction

    // Send one op; gaps open between bursts when enabled, valid stays high within a burst
    task automatic send_op(logic [bdq_pkg::OP_W-1:0] op, bdq_pkg::data_t value);
        deque_cmd_t cmd;
        int         gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (tx_gaps_on) begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        cmd = '0;
        cmd.op = op;
        cmd.value = value;
        s_tvalid <= 1'b1;
        s_tdata  <= cmd;
        do @(posedge aclk); while (!(aresetn && s_tready));
        pending_results.push_back(apply_deque_op(op, value));
    endtask

    // Stop sending until every pending result has arrived
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Pops, finds and unused codes on an empty store
    task automatic test_empty_store();
        send_op(bdq_pkg::OP_POP_FRONT, '0);
        send_op(bdq_pkg::OP_POP_BACK, '1);
        send_op(bdq_pkg::OP_SEARCH, '0);
        send_op(OP_UNUSED_6, '1);
        send_op(OP_UNUSED_7, bdq_pkg::data_t'(32'h5555_AAAA));
    endtask

    // Fill to DEPTH from both ends, then push into a full store at each end
    task automatic test_full_store();
        send_op(bdq_pkg::OP_PUSH_BACK, '0);
        send_op(bdq_pkg::OP_PUSH_FRONT, '1);
        for (int i = 2; i < bdq_pkg::DEPTH; i++) begin
            if (i == 5 || i == 11)
                send_op(bdq_pkg::OP_PUSH_BACK, bdq_pkg::data_t'(32'h5A5A_5A5A));
            else
                send_op((i % 2) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK,
                        bdq_pkg::data_t'(32'h1000_0000 + i));
        end
        send_op(bdq_pkg::OP_PUSH_FRONT, bdq_pkg::data_t'(32'h0000_1234));
        send_op(bdq_pkg::OP_PUSH_BACK, bdq_pkg::data_t'(32'h8000_0000));
    endtask

    // Hits and misses on a full store; duplicate removal takes the first match
    task automatic test_middle_remove();
        send_op(bdq_pkg::OP_SEARCH, '1);
        send_op(bdq_pkg::OP_REMOVE, bdq_pkg::data_t'(32'h5A5A_5A5A));
        send_op(bdq_pkg::OP_SEARCH, bdq_pkg::data_t'(32'hDEAD_BEEF));
        send_op(bdq_pkg::OP_REMOVE, bdq_pkg::data_t'(32'hDEAD_BEEF));
        send_op(bdq_pkg::OP_POP_FRONT, '0);
        send_op(bdq_pkg::OP_POP_BACK, '0);
    endtask

    // Random op mix; weights in percent, the rest after unused codes, pushes and pops are searches and removes
    task automatic test_random_mix(int count, int push_w, int pop_w, bit gaps);
        int                       r;
        logic [bdq_pkg::OP_W-1:0] op;
        tx_gaps_on = gaps;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                op = $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
            else if (r < 3 + push_w)
                op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
            else if (r < 3 + push_w + pop_w)
                op = $urandom_range(0, 1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
            else
                op = $urandom_range(0, 1) ? bdq_pkg::OP_SEARCH : bdq_pkg::OP_REMOVE;
            send_op(op, pick_value());
        end
    endtask

    // Receiver: free-running windows with no stalls, otherwise periodic plus random stalls
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if ((rx_cycle % 256) < 64)
            m_tready <= 1'b1;
        else
            m_tready <= !((rx_cycle % 19) < 4 || $urandom_range(0, 4) == 0);
    end

    task automatic check_field(string name, logic [bdq_pkg::DOUT_W-1:0] want,
                               logic [bdq_pkg::DOUT_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Compare each result transfer with the oldest pending result
    always @(posedge aclk) begin
        deque_result_t got;
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                check_field("data_out", want.data_out, got.data_out);
                check_field("found", bdq_pkg::DOUT_W'(want.found),
                            bdq_pkg::DOUT_W'(got.found));
                check_field("status", bdq_pkg::DOUT_W'(want.status),
                            bdq_pkg::DOUT_W'(got.status));
                check_field("occupancy", bdq_pkg::DOUT_W'(want.occupancy),
                            bdq_pkg::DOUT_W'(got.occupancy));
            end
        end
    end

    // Run limit
    initial begin
        #2_400_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        tx_gaps_on = 1'b1;
        test_empty_store();
        test_full_store();
        test_middle_remove();
        wait_for_results();

        test_random_mix(60, 70, 15, 1'b1);
        test_random_mix(60, 45, 40, 1'b0);
        test_random_mix(60, 15, 70, 1'b1);
        wait_for_results();
        test_random_mix(60, 30, 30, 1'b1);
        test_random_mix(60, 75, 10, 1'b0);
        test_random_mix(60, 10, 75, 1'b1);
        test_random_mix(50, 40, 40, 1'b1);
        wait_for_results();

        // Let any stray result show up
        repeat (4) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
